>>> rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared sizes, command codes and the command record of the min-min scheduler.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int MAX_JOBS     = 64;
  localparam int MAX_MACHINES = 16;
  localparam int SLOT_W       = $clog2(MAX_JOBS);
  localparam int MACH_W       = $clog2(MAX_MACHINES);
  localparam int NJ_W         = 7;
  localparam int NM_W         = 5;
  localparam int IDENT_W      = 16;
  localparam int REL_W        = 20;
  localparam int TV_W         = 20;
  localparam int PROC_W       = 16;
  localparam int TIME_W       = 23;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_LOAD_READY = 2'd0;
  localparam logic [1:0] MODE_LOAD_JOB   = 2'd1;
  localparam logic [1:0] MODE_RUN        = 2'd2;

  localparam logic REG_JOBS     = 1'b0;
  localparam logic REG_MACHINES = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_READY,
    OP_LOAD_JOB,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [IDENT_W-1:0] ident;
    logic [MACH_W-1:0]  mach;
    logic [REL_W-1:0]   rel;
    logic [TV_W-1:0]    tv;
  } cmd_t;

endpackage

>>> rtl/mms_ifs.sv
// ----------------------------------------------------------------------------
// mms_ifs
// Valid/ready channels for input items and schedule results.
// ----------------------------------------------------------------------------
interface mms_item_if import mms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [SLOT_W-1:0]  job_slot;
  logic [IDENT_W-1:0] job_ident;
  logic [MACH_W-1:0]  machine_index;
  logic [REL_W-1:0]   release_at;
  logic [TV_W-1:0]    time_value;

  modport source(output valid, mode, job_slot, job_ident, machine_index, release_at,
                 time_value, input ready);
  modport sink(input valid, mode, job_slot, job_ident, machine_index, release_at,
               time_value, output ready);
endinterface

interface mms_result_if import mms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDENT_W-1:0] assigned_job;
  logic [MACH_W-1:0]  assigned_machine;
  logic [TIME_W-1:0]  finish_time;
  logic               last_assignment;

  modport source(output valid, assigned_job, assigned_machine, finish_time,
                 last_assignment, input ready);
  modport sink(input valid, assigned_job, assigned_machine, finish_time,
               last_assignment, output ready);
endinterface

>>> rtl/mms_front.sv
// ----------------------------------------------------------------------------
// mms_front
// Accepts input items, decodes the mode and forwards commands to the queue.
// ----------------------------------------------------------------------------
module mms_front import mms_pkg::*; (
  mms_item_if.sink items,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     cmd
);

  logic known;

  always_comb begin
    known     = 1'b1;
    cmd.op    = OP_RUN;
    cmd.slot  = items.job_slot;
    cmd.ident = items.job_ident;
    cmd.mach  = items.machine_index;
    cmd.rel   = items.release_at;
    cmd.tv    = items.time_value;
    unique case (items.mode)
      MODE_LOAD_READY: cmd.op = OP_LOAD_READY;
      MODE_LOAD_JOB:   cmd.op = OP_LOAD_JOB;
      MODE_RUN:        cmd.op = OP_RUN;
      default:         known  = 1'b0;
    endcase
  end

  assign items.ready = !queue_full;
  // drop unknown modes here
  assign push = items.valid && !queue_full && known;

endmodule

>>> rtl/mms_queue.sv
// ----------------------------------------------------------------------------
// mms_queue
// Short command queue between the front end and the scheduling engine.
// ----------------------------------------------------------------------------
module mms_queue import mms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/mms_back.sv
// ----------------------------------------------------------------------------
// mms_back
// Executes load commands and runs the min-min search, one job/machine pair
// per cycle, through a three-stage compare pipeline.
// ----------------------------------------------------------------------------
module mms_back import mms_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_avail,
  input  cmd_t            cmd,
  output logic            pop,
  input  logic [NJ_W-1:0] jobs_in_use,
  input  logic [NM_W-1:0] machines_in_use,
  mms_result_if.source    results
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t state;

  logic [PROC_W-1:0]  proc_mem  [MAX_JOBS*MAX_MACHINES];
  logic [REL_W-1:0]   rel_mem   [MAX_JOBS];
  logic [IDENT_W-1:0] ident_mem [MAX_JOBS];
  logic [PROC_W-1:0]  proc_q;
  logic [REL_W-1:0]   rel_q;
  logic [IDENT_W-1:0] ident_q;

  logic [TIME_W-1:0]  init_ready [MAX_MACHINES];
  logic [TIME_W-1:0]  work_ready [MAX_MACHINES];
  logic [MAX_JOBS-1:0] flags;

  logic [NJ_W-1:0]   run_nj;
  logic [NM_W-1:0]   run_nm;
  logic [NJ_W-1:0]   step;
  logic [SLOT_W-1:0] j_cnt;
  logic [MACH_W-1:0] m_cnt;
  logic              drain_cnt;
  logic              last_m;
  logic              last_j;

  // data stage
  logic              v1;
  logic              first1;
  logic              last1;
  logic [MACH_W-1:0] m1;
  logic [SLOT_W-1:0] slot1;
  logic [TIME_W-1:0] start1;
  logic [TIME_W-1:0] done1;
  logic              take1;
  logic [TIME_W-1:0] acc_done;
  logic [PROC_W-1:0] acc_proc;
  logic [MACH_W-1:0] acc_mach;
  logic [TIME_W-1:0] cand_done;
  logic [PROC_W-1:0] cand_proc;
  logic [MACH_W-1:0] cand_mach;

  // job stage
  logic               v2;
  logic [TIME_W-1:0]  j2_done;
  logic [PROC_W-1:0]  j2_proc;
  logic [MACH_W-1:0]  j2_mach;
  logic [SLOT_W-1:0]  j2_slot;
  logic [IDENT_W-1:0] j2_ident;
  logic               take2;

  // winner of the current step
  logic               win_have;
  logic [TIME_W-1:0]  win_done;
  logic [PROC_W-1:0]  win_proc;
  logic [MACH_W-1:0]  win_mach;
  logic [SLOT_W-1:0]  win_slot;
  logic [IDENT_W-1:0] win_ident;

  logic emit_ok;

  assign pop     = (state == S_IDLE) && cmd_avail;
  assign last_m  = ({1'b0, m_cnt} == run_nm - 1'b1);
  assign last_j  = ({1'b0, j_cnt} == run_nj - 1'b1);
  assign emit_ok = !results.valid || results.ready;

  always_comb begin
    start1 = work_ready[m1];
    if (start1 < TIME_W'(rel_q)) start1 = TIME_W'(rel_q);
    done1 = start1 + TIME_W'(proc_q);
    take1 = first1 || (done1 < acc_done) || ((done1 == acc_done) && (proc_q < acc_proc));
    cand_done = take1 ? done1  : acc_done;
    cand_proc = take1 ? proc_q : acc_proc;
    cand_mach = take1 ? m1     : acc_mach;
  end

  assign take2 = !win_have || (j2_done < win_done) ||
                 ((j2_done == win_done) && (j2_proc < win_proc)) ||
                 ((j2_done == win_done) && (j2_proc == win_proc) && (j2_ident < win_ident));

  // storage for job tables
  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_LOAD_JOB) begin
      proc_mem[{cmd.slot, cmd.mach}] <= cmd.tv[PROC_W-1:0];
      rel_mem[cmd.slot]              <= cmd.rel;
      ident_mem[cmd.slot]            <= cmd.ident;
    end
    proc_q  <= proc_mem[{j_cnt, m_cnt}];
    rel_q   <= rel_mem[j_cnt];
    ident_q <= ident_mem[j_cnt];
  end

  // compare pipeline payload
  always_ff @(posedge clk) begin
    m1     <= m_cnt;
    slot1  <= j_cnt;
    first1 <= (m_cnt == '0);
    last1  <= last_m;
    if (v1) begin
      acc_done <= cand_done;
      acc_proc <= cand_proc;
      acc_mach <= cand_mach;
    end
    if (v1 && last1) begin
      j2_done  <= cand_done;
      j2_proc  <= cand_proc;
      j2_mach  <= cand_mach;
      j2_slot  <= slot1;
      j2_ident <= ident_q;
    end
    if (v2 && take2) begin
      win_done  <= j2_done;
      win_proc  <= j2_proc;
      win_mach  <= j2_mach;
      win_slot  <= j2_slot;
      win_ident <= j2_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      init_ready    <= '{default: '0};
      work_ready    <= '{default: '0};
      flags         <= '0;
      run_nj        <= '0;
      run_nm        <= '0;
      step          <= '0;
      j_cnt         <= '0;
      m_cnt         <= '0;
      drain_cnt     <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      win_have      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN) && !flags[j_cnt];
      v2 <= v1 && last1;
      if (v2 && take2) win_have <= 1'b1;
      // the emit state loads the next transfer itself
      if (results.valid && results.ready && state != S_EMIT) results.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (cmd.op)
              OP_LOAD_READY: init_ready[cmd.mach] <= TIME_W'(cmd.tv);
              OP_LOAD_JOB: ;
              OP_RUN: begin
                if (jobs_in_use != '0 && machines_in_use != '0) begin
                  run_nj     <= (jobs_in_use > NJ_W'(MAX_JOBS)) ?
                                NJ_W'(MAX_JOBS) : jobs_in_use;
                  run_nm     <= (machines_in_use > NM_W'(MAX_MACHINES)) ?
                                NM_W'(MAX_MACHINES) : machines_in_use;
                  work_ready <= init_ready;
                  flags      <= '0;
                  step       <= '0;
                  j_cnt      <= '0;
                  m_cnt      <= '0;
                  win_have   <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (last_m) begin
            m_cnt <= '0;
            if (last_j) begin
              drain_cnt <= 1'b0;
              state     <= S_DRAIN;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
          end else begin
            m_cnt <= m_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          // wait for the last job to leave the compare stages
          drain_cnt <= 1'b1;
          if (drain_cnt) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            results.valid            <= 1'b1;
            results.assigned_job     <= win_ident;
            results.assigned_machine <= win_mach;
            results.finish_time      <= win_done;
            results.last_assignment  <= (step + 1'b1 == run_nj);
            work_ready[win_mach]     <= win_done;
            flags[win_slot]          <= 1'b1;
            step                     <= step + 1'b1;
            win_have                 <= 1'b0;
            j_cnt                    <= '0;
            m_cnt                    <= '0;
            state                    <= (step + 1'b1 == run_nj) ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_flags_match_step: assert property (@(posedge clk) disable iff (rst)
    $countones(flags) == int'(step))
    else $error("scheduled flag count differs from step count");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit");

  a_job_stage_source: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1 && last1))
    else $error("job stage valid without a finished job");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> !v1 && !v2)
    else $error("command taken while compare pipeline busy");

endmodule

>>> rtl/min_min_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// min_min_job_scheduler_unit
// Min-min list scheduler for unrelated machines.
// ----------------------------------------------------------------------------
// Channels: items (valid/ready) carries load and run commands; results
// (valid/ready) carries one transfer per job assignment. The user must write
// the two registers jobs_in_use and machines_in_use through cfg_we/cfg_index/
// cfg_data only while the unit is idle; the unit does not enforce this.
// Items enter a four-entry command queue; while it has room, items is ready
// every cycle. The engine completes a load command as it pops it from the
// queue. A run with J jobs and M machines has J steps; each step scans all
// J*M job/machine pairs, one pair per cycle through the compare pipeline,
// then drains the compare stages and emits one result.
// A stalled results channel holds the engine at the emit point of the
// current step; the queue keeps taking items until it fills.
// Reset clears the queue, ready times, scheduled flags and the output
// register and sets both registers to one. Job tables need no reset.
// ----------------------------------------------------------------------------
module min_min_job_scheduler_unit import mms_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [NJ_W-1:0] cfg_data,
  mms_item_if.sink        items,
  mms_result_if.source    results
);

  logic [NJ_W-1:0] jobs_in_use;
  logic [NM_W-1:0] machines_in_use;
  logic            push;
  logic            full;
  logic            pop;
  logic            avail;
  cmd_t            push_cmd;
  cmd_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_in_use     <= NJ_W'(1);
      machines_in_use <= NM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JOBS:     jobs_in_use     <= cfg_data;
        REG_MACHINES: machines_in_use <= cfg_data[NM_W-1:0];
        default: ;
      endcase
    end
  end

  mms_front u_front (
    .items      (items),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  mms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  mms_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_avail       (avail),
    .cmd             (head),
    .pop             (pop),
    .jobs_in_use     (jobs_in_use),
    .machines_in_use (machines_in_use),
    .results         (results)
  );

endmodule

>>> sim/min_min_job_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// min_min_job_scheduler_unit_test
// Self-checking bench for the min-min scheduler: loads ready times and job
// tables, runs schedules under many register settings and checks every
// assignment transfer against a local min-min predictor, or against listed
// values for the directed runs, with random stalls on both channels.
// ----------------------------------------------------------------------------
module min_min_job_scheduler_unit_test;
  import mms_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT  = 20000;
  localparam int         ITEM_TARGET = 450;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SLOT_W-1:0]  slot;
    logic [IDENT_W-1:0] ident;
    logic [MACH_W-1:0]  mach;
    logic [REL_W-1:0]   rel;
    logic [TV_W-1:0]    tv;
  } sched_item_t;

  typedef struct packed {
    logic [IDENT_W-1:0] job;
    logic [MACH_W-1:0]  mach;
    logic [TIME_W-1:0]  done;
    logic               last;
  } assignment_t;

  typedef struct packed {
    sched_item_t it;
    logic        typed;
    assignment_t want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [NJ_W-1:0] cfg_data;

  mms_item_if   item_ch();
  mms_result_if result_ch();

  min_min_job_scheduler_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(item_ch),
    .results(result_ch)
  );

  // predictor state
  int unsigned      jobs_reg;
  int unsigned      machines_reg;
  logic [TIME_W-1:0]  ready_init [MAX_MACHINES];
  logic [TIME_W-1:0]  ready_work [MAX_MACHINES];
  logic [PROC_W-1:0]  proc_tab [MAX_JOBS][MAX_MACHINES];
  logic [REL_W-1:0]   rel_tab [MAX_JOBS];
  logic [IDENT_W-1:0] ident_tab [MAX_JOBS];
  bit                 placed [MAX_JOBS];
  bit                 loaded [MAX_JOBS][MAX_MACHINES];

  assignment_t pending_assignments[$];
  assignment_t run_out[$];
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          sink_busy_free = 0;
  bit          source_busy_free = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Min-min over the slots and machines in use; fills run_out.
  function automatic void schedule_jobs();
    int unsigned nj, nm, step, j, m;
    int unsigned start, proc, done, best_done, best_proc, best_mach;
    int unsigned win_slot, win_mach, win_done, win_proc;
    bit have, any;
    nj = jobs_reg > MAX_JOBS ? MAX_JOBS : jobs_reg;
    nm = machines_reg > MAX_MACHINES ? MAX_MACHINES : machines_reg;
    run_out.delete();
    if (nj == 0 || nm == 0) return;
    for (m = 0; m < MAX_MACHINES; m++) ready_work[m] = ready_init[m];
    for (j = 0; j < MAX_JOBS; j++) placed[j] = 1'b0;
    for (step = 0; step < nj; step++) begin
      have = 1'b0;
      win_slot = 0; win_mach = 0; win_done = 0; win_proc = 0;
      for (j = 0; j < nj; j++) begin
        if (placed[j]) continue;
        any = 1'b0;
        best_done = 0; best_proc = 0; best_mach = 0;
        for (m = 0; m < nm; m++) begin
          start = ready_work[m];
          if (start < rel_tab[j]) start = rel_tab[j];
          proc = proc_tab[j][m];
          done = start + proc;
          if (!any || done < best_done || (done == best_done && proc < best_proc)) begin
            any = 1'b1;
            best_done = done;
            best_proc = proc;
            best_mach = m;
          end
        end
        if (!have || best_done < win_done ||
            (best_done == win_done && best_proc < win_proc) ||
            (best_done == win_done && best_proc == win_proc &&
             ident_tab[j] < ident_tab[win_slot])) begin
          have = 1'b1;
          win_slot = j;
          win_mach = best_mach;
          win_done = best_done;
          win_proc = best_proc;
        end
      end
      ready_work[win_mach] = win_done[TIME_W-1:0];
      placed[win_slot] = 1'b1;
      run_out.push_back('{job: ident_tab[win_slot], mach: win_mach[MACH_W-1:0],
                          done: win_done[TIME_W-1:0], last: (step + 1 == nj)});
    end
  endfunction

  // Mostly tiny values so that ties happen; now and then the full range.
  function automatic logic [TV_W-1:0] pick_time();
    if ($urandom_range(0, 9) < 6) return TV_W'($urandom_range(0, 7));
    return TV_W'($urandom());
  endfunction

  task automatic send_item(input sched_item_t it, input bit typed, input assignment_t want);
    int gap;
    gap = source_busy_free ? 0 : $urandom_range(0, 18);
    repeat (gap) @(negedge clk);
    item_ch.valid         = 1'b1;
    item_ch.mode          = it.mode;
    item_ch.job_slot      = it.slot;
    item_ch.job_ident     = it.ident;
    item_ch.machine_index = it.mach;
    item_ch.release_at    = it.rel;
    item_ch.time_value    = it.tv;
    do @(posedge clk); while (!item_ch.ready);
    case (it.mode)
      MODE_LOAD_READY: ready_init[it.mach] = TIME_W'(it.tv);
      MODE_LOAD_JOB: begin
        ident_tab[it.slot] = it.ident;
        rel_tab[it.slot] = it.rel;
        proc_tab[it.slot][it.mach] = it.tv[PROC_W-1:0];
        loaded[it.slot][it.mach] = 1'b1;
      end
      MODE_RUN: begin
        schedule_jobs();
        if (typed) pending_assignments.push_back(want);
        else foreach (run_out[k]) pending_assignments.push_back(run_out[k]);
      end
      default: ;
    endcase
    if (it.mode != MODE_UNUSED) items_sent++;
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [NJ_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_JOBS) jobs_reg = value;
    else machines_reg = value[NM_W-1:0];
  endtask

  task automatic wait_drained();
    while (pending_assignments.size() != 0) @(negedge clk);
    // loads queued behind the last run still need the engine
    repeat (20) @(negedge clk);
  endtask

  // result side: random back-pressure
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_assignments.size() == 0) begin
        $error("unexpected assignment job %0d machine %0d",
               result_ch.assigned_job, result_ch.assigned_machine);
        errors++;
      end else begin
        assignment_t exp_a;
        exp_a = pending_assignments.pop_front();
        if (result_ch.assigned_job !== exp_a.job) begin
          $error("assigned_job expected %0d got %0d", exp_a.job, result_ch.assigned_job);
          errors++;
        end
        if (result_ch.assigned_machine !== exp_a.mach) begin
          $error("assigned_machine expected %0d got %0d", exp_a.mach,
                 result_ch.assigned_machine);
          errors++;
        end
        if (result_ch.finish_time !== exp_a.done) begin
          $error("finish_time expected %0d got %0d", exp_a.done,
                 result_ch.finish_time);
          errors++;
        end
        if (result_ch.last_assignment !== exp_a.last) begin
          $error("last_assignment expected %0d got %0d", exp_a.last,
                 result_ch.last_assignment);
          errors++;
        end
      end
      if ($urandom_range(0, 15) == 0) sink_busy_free = !sink_busy_free;
      stall_left = sink_busy_free ? 0 : $urandom_range(0, 18);
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  directed_row_t directed_rows [13];

  initial begin
    int unsigned nj, nm, phase, n;
    sched_item_t it;
    assignment_t none;
    none = '0;
    directed_rows = '{
      '{'{MODE_LOAD_READY, 6'd0, 16'd0, 4'd0, 20'd0, 20'd0}, 1'b0, '0},
      '{'{MODE_LOAD_JOB, 6'd0, 16'hFFFF, 4'd0, 20'd0, 20'hFFFF}, 1'b0, '0},
      '{'{MODE_RUN, 6'd0, 16'd0, 4'd0, 20'd0, 20'd0}, 1'b1,
        '{16'hFFFF, 4'd0, 23'd65535, 1'b1}},
      '{'{MODE_LOAD_JOB, 6'd0, 16'd0, 4'd0, 20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
      '{'{MODE_RUN, 6'd63, 16'hFFFF, 4'd15, 20'hFFFFF, 20'hFFFFF}, 1'b1,
        '{16'd0, 4'd0, 23'd1114110, 1'b1}},
      '{'{MODE_LOAD_READY, 6'd0, 16'd0, 4'd0, 20'd0, 20'hFFFFF}, 1'b0, '0},
      '{'{MODE_LOAD_JOB, 6'd0, 16'h1234, 4'd0, 20'd0, 20'd0}, 1'b0, '0},
      '{'{MODE_RUN, 6'd0, 16'd0, 4'd0, 20'd0, 20'd0}, 1'b1,
        '{16'h1234, 4'd0, 23'd1048575, 1'b1}},
      '{'{MODE_UNUSED, 6'd63, 16'hFFFF, 4'd15, 20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
      '{'{MODE_RUN, 6'd0, 16'd0, 4'd0, 20'd0, 20'd0}, 1'b0, '0},
      '{'{MODE_LOAD_READY, 6'd0, 16'd0, 4'd15, 20'd0, 20'd5}, 1'b0, '0},
      '{'{MODE_LOAD_JOB, 6'd63, 16'd7, 4'd15, 20'd3, 20'h10005}, 1'b0, '0},
      '{'{MODE_LOAD_READY, 6'd0, 16'd0, 4'd0, 20'd0, 20'd0}, 1'b0, '0}
    };
    jobs_reg = 1;
    machines_reg = 1;
    foreach (ready_init[m]) begin
      ready_init[m] = '0;
      ready_work[m] = '0;
    end
    foreach (loaded[j, m]) begin
      loaded[j][m] = 1'b0;
      proc_tab[j][m] = '0;
    end
    foreach (rel_tab[j]) begin
      rel_tab[j] = '0;
      ident_tab[j] = '0;
      placed[j] = 1'b0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_JOBS;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_LOAD_READY;
    item_ch.job_slot = '0;
    item_ch.job_ident = '0;
    item_ch.machine_index = '0;
    item_ch.release_at = '0;
    item_ch.time_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r])
      send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);
    // run once more with the job on slot 63 in range
    wait_drained();
    write_reg(REG_JOBS, 7'd64);

    // first phases hit the register extremes, later ones stay small
    phase = 0;
    while (items_sent < ITEM_TARGET || phase < 6) begin
      wait_drained();
      case (phase)
        0: begin nj = 64;  nm = 1;  end
        1: begin nj = 2;   nm = 16; end
        2: begin nj = 0;   nm = 3;  end
        3: begin nj = 4;   nm = 0;  end
        4: begin nj = 127; nm = 2;  end
        5: begin nj = 3;   nm = 31; end
        default: begin
          nj = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          nm = $urandom_range(1, 4);
        end
      endcase
      write_reg(REG_JOBS, NJ_W'(nj));
      write_reg(REG_MACHINES, NJ_W'(nm));
      source_busy_free = ($urandom_range(0, 3) == 0);
      nj = nj > MAX_JOBS ? MAX_JOBS : nj;
      nm = nm > MAX_MACHINES ? MAX_MACHINES : nm;
      // every table entry the run will read gets written first
      for (int j = 0; j < nj; j++)
        for (int m = 0; m < nm; m++)
          if (!loaded[j][m]) begin
            it = '{MODE_LOAD_JOB, SLOT_W'(j),
                   ($urandom_range(0, 1) ? IDENT_W'($urandom_range(0, 3)) : IDENT_W'($urandom())),
                   MACH_W'(m), pick_time(), pick_time()};
            send_item(it, 1'b0, none);
          end
      for (int rep = 0; rep < ($urandom_range(0, 3) == 0 ? 2 : 1); rep++) begin
        n = $urandom_range(2, 10);
        for (int k = 0; k < n; k++) begin
          it.mode = ($urandom_range(0, 9) < 3) ? MODE_LOAD_READY :
                    ($urandom_range(0, 9) == 0) ? MODE_UNUSED : MODE_LOAD_JOB;
          it.slot = ($urandom_range(0, 4) == 0 || nj == 0) ? SLOT_W'($urandom())
                                                            : SLOT_W'($urandom_range(0, nj - 1));
          it.ident = $urandom_range(0, 1) ? IDENT_W'($urandom_range(0, 3)) : IDENT_W'($urandom());
          it.mach = ($urandom_range(0, 4) == 0 || nm == 0) ? MACH_W'($urandom())
                                                           : MACH_W'($urandom_range(0, nm - 1));
          it.rel = pick_time();
          it.tv = pick_time();
          // a job load only fills its own entry and the slot's release time and ident,
          // as the predictor tables also record
          send_item(it, 1'b0, none);
        end
        it = '{MODE_RUN, SLOT_W'($urandom()), IDENT_W'($urandom()), MACH_W'($urandom()),
               REL_W'($urandom()), TV_W'($urandom())};
        send_item(it, 1'b0, none);
      end
      phase++;
    end

    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_assignments.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> min_min_job_scheduler_unit.f
rtl/mms_pkg.sv
rtl/mms_ifs.sv
rtl/mms_front.sv
rtl/mms_queue.sv
rtl/mms_back.sv
rtl/min_min_job_scheduler_unit.sv
sim/min_min_job_scheduler_unit_test.sv
